[design/seb_pkg.sv]
// Shared types, widths, codes and helper functions for the segment/box edge test.
package seb_pkg;

    localparam int CW     = 24;          // coordinate width, signed fixed point
    localparam int CFG_IW = 8;           // configuration index width
    localparam int VW     = CW + 2;      // working width for edges and hit points
    localparam int PW     = 2 * CW + 2;  // product width ahead of the divider
    localparam int QW     = CW + 1;      // quotient bits, one per divider stage
    localparam int SW     = 2 * CW + 1;  // squared distance width
    localparam int NE     = 4;           // edges: top, bottom, left, right

    typedef enum logic [CFG_IW-1:0] {
        CFG_CENTER_X = CFG_IW'(0),
        CFG_CENTER_Y = CFG_IW'(1),
        CFG_WIDTH    = CFG_IW'(2),
        CFG_HEIGHT   = CFG_IW'(3)
    } cfg_index_t;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_EDGE_H = 2'd1;
    localparam logic [1:0] KIND_EDGE_V = 2'd2;
    localparam logic [1:0] KIND_CORNER = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] seg_start_x;
        logic signed [CW-1:0] seg_start_y;
        logic signed [CW-1:0] seg_end_x;
        logic signed [CW-1:0] seg_end_y;
    } seg_req_t;

    typedef struct packed {
        logic [1:0]           hit_kind;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
    } hit_res_t;

    function automatic logic in_range(input logic signed [VW-1:0] v,
                                      input logic signed [VW-1:0] a,
                                      input logic signed [VW-1:0] b);
        logic signed [VW-1:0] lo;
        logic signed [VW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [VW-1:0] mag(input logic signed [VW-1:0] v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

endpackage

[design/segment_box_edge_intersection.sv]
// Top level: pipelined test of a segment against the top, bottom, left and right edges of a box.
//
// A request (one segment) is taken at each rising edge where start is high and
// busy is low. busy never rises: a new request may enter in every cycle.
// The result (hit kind, hit point) appears on res with done high for one
// cycle. Throughput is one request per cycle. The long-division pipeline,
// one quotient bit per stage and one divider per edge, follows a multiplier
// stage and precedes the range check, distance squaring and two-level
// nearest-hit selection.
// The box is set through the configuration channel (center x, center y, full
// width, full height); cfg_ready is always high and writes are meant for idle
// periods only. Unknown register indexes are ignored.
// Reset clears the box registers to zero and drops every request in flight.
// The receiver cannot stall; results are strobed once and not held.
module segment_box_edge_intersection (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  seb_pkg::seg_req_t           req,
    output logic                        done,
    output seb_pkg::hit_res_t           res,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [seb_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [seb_pkg::CW-1:0]      cfg_data
);

    localparam int CW = seb_pkg::CW;
    localparam int VW = seb_pkg::VW;
    localparam int PW = seb_pkg::PW;
    localparam int QW = seb_pkg::QW;
    localparam int SW = seb_pkg::SW;
    localparam int NE = seb_pkg::NE;

    typedef struct packed {
        logic signed [VW-1:0]      sx;
        logic signed [VW-1:0]      sy;
        logic signed [VW-1:0]      ex;
        logic signed [VW-1:0]      ey;
        logic signed [VW-1:0]      dx;
        logic signed [VW-1:0]      dy;
        logic [NE-1:0][VW-1:0]     num;
        logic [NE-1:0]             ewin;
    } st1_t;

    typedef struct packed {
        logic signed [VW-1:0] sx;
        logic signed [VW-1:0] sy;
        logic signed [VW-1:0] ex;
        logic signed [VW-1:0] ey;
        logic                 dx0;
        logic                 dy0;
        logic [NE-1:0]        ewin;
        logic [NE-1:0]        neg;
    } side_t;

    typedef struct packed {
        logic [CW:0]   r;
        logic [QW-1:0] w;
        logic [CW-1:0] d;
    } div_t;

    typedef struct packed {
        logic signed [VW-1:0]  sx;
        logic signed [VW-1:0]  sy;
        logic [NE-1:0]         hit;
        logic [NE-1:0][VW-1:0] hx;
        logic [NE-1:0][VW-1:0] hy;
    } st3_t;

    typedef struct packed {
        logic [NE-1:0]         hit;
        logic [NE-1:0][VW-1:0] hx;
        logic [NE-1:0][VW-1:0] hy;
        logic [NE-1:0][CW-1:0] ax;
        logic [NE-1:0][CW-1:0] ay;
        logic [NE-1:0][NE-1:0] eq;
    } st4_t;

    typedef struct packed {
        logic [NE-1:0]         hit;
        logic [NE-1:0][VW-1:0] hx;
        logic [NE-1:0][VW-1:0] hy;
        logic [NE-1:0][NE-1:0] eq;
        logic [NE-1:0][SW-1:0] dsq;
    } st5_t;

    typedef struct packed {
        logic [NE-1:0]         hit;
        logic [NE-1:0][VW-1:0] hx;
        logic [NE-1:0][VW-1:0] hy;
        logic [NE-1:0][NE-1:0] eq;
        logic [1:0][1:0]       pidx;
        logic [1:0]            phit;
        logic [1:0][SW-1:0]    pd;
    } st6_t;

    // Box registers.
    logic signed [CW-1:0] cx_reg;
    logic signed [CW-1:0] cy_reg;
    logic [CW-2:0]        w_reg;
    logic [CW-2:0]        h_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            w_reg  <= '0;
            h_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                seb_pkg::CFG_CENTER_X: cx_reg <= signed'(cfg_data);
                seb_pkg::CFG_CENTER_Y: cy_reg <= signed'(cfg_data);
                seb_pkg::CFG_WIDTH:    w_reg  <= cfg_data[CW-2:0];
                seb_pkg::CFG_HEIGHT:   h_reg  <= cfg_data[CW-2:0];
                default:
                begin
                end
            endcase
        end
    end

    // Edge positions at full precision.
    logic signed [VW-1:0] hw_s, hh_s, lx, rx, ty, by;

    always_comb
    begin
        hw_s = signed'(VW'({1'b0, w_reg[CW-2:1]}));
        hh_s = signed'(VW'({1'b0, h_reg[CW-2:1]}));
        lx   = VW'(cx_reg) - hw_s;
        rx   = VW'(cx_reg) + hw_s;
        ty   = VW'(cy_reg) - hh_s;
        by   = VW'(cy_reg) + hh_s;
    end

    // Stage 1: deltas, numerators and whether each edge line crosses the span.
    st1_t s1_next, s1_reg;
    logic v1_reg;

    always_comb
    begin
        s1_next.sx     = VW'(req.seg_start_x);
        s1_next.sy     = VW'(req.seg_start_y);
        s1_next.ex     = VW'(req.seg_end_x);
        s1_next.ey     = VW'(req.seg_end_y);
        s1_next.dx     = s1_next.ex - s1_next.sx;
        s1_next.dy     = s1_next.ey - s1_next.sy;
        s1_next.num[0] = ty - s1_next.sy;
        s1_next.num[1] = by - s1_next.sy;
        s1_next.num[2] = lx - s1_next.sx;
        s1_next.num[3] = rx - s1_next.sx;
        s1_next.ewin[0] = seb_pkg::in_range(ty, s1_next.sy, s1_next.ey);
        s1_next.ewin[1] = seb_pkg::in_range(by, s1_next.sy, s1_next.ey);
        s1_next.ewin[2] = seb_pkg::in_range(lx, s1_next.sx, s1_next.ex);
        s1_next.ewin[3] = seb_pkg::in_range(rx, s1_next.sx, s1_next.ex);
    end

    // Stage 2: product magnitudes and result signs, then the divider stages.
    side_t                side_reg [0:QW];
    div_t                 div_reg  [0:QW][0:NE-1];
    div_t                 div_next [0:QW][0:NE-1];
    logic [QW:0]          vd_reg;
    side_t                side0_next;
    logic signed [VW-1:0] numv [NE];
    logic signed [VW-1:0] scale [NE];
    logic signed [VW-1:0] den [NE];
    logic [VW-1:0]        scale_m [NE];
    logic [VW-1:0]        den_m [NE];
    logic [PW-1:0]        prod [NE];
    logic [CW+1:0]        trial [0:QW-1][NE];
    logic [CW+1:0]        diff [0:QW-1][NE];
    logic                 ge [0:QW-1][NE];

    always_comb
    begin
        side0_next.sx  = s1_reg.sx;
        side0_next.sy  = s1_reg.sy;
        side0_next.ex  = s1_reg.ex;
        side0_next.ey  = s1_reg.ey;
        side0_next.dx0 = (s1_reg.dx == '0);
        side0_next.dy0 = (s1_reg.dy == '0);
        side0_next.ewin = s1_reg.ewin;
        for (int e = 0; e < NE; e++)
        begin
            numv[e]    = signed'(s1_reg.num[e]);
            scale[e]   = (e < 2) ? s1_reg.dx : s1_reg.dy;
            den[e]     = (e < 2) ? s1_reg.dy : s1_reg.dx;
            scale_m[e] = seb_pkg::mag(scale[e]);
            den_m[e]   = seb_pkg::mag(den[e]);
            prod[e]    = PW'(seb_pkg::mag(numv[e])) * PW'(scale_m[e][CW-1:0]);
            side0_next.neg[e] = numv[e][VW-1] ^ scale[e][VW-1] ^ den[e][VW-1];
            div_next[0][e].r = prod[e][PW-1:QW];
            div_next[0][e].w = prod[e][QW-1:0];
            div_next[0][e].d = den_m[e][CW-1:0];
        end
        // One restoring-division step per stage, independent per stage.
        for (int k = 0; k < QW; k++)
        begin
            for (int e = 0; e < NE; e++)
            begin
                trial[k][e] = {div_reg[k][e].r, div_reg[k][e].w[QW-1]};
                ge[k][e]    = (trial[k][e] >= {2'b00, div_reg[k][e].d});
                diff[k][e]  = trial[k][e] - {2'b00, div_reg[k][e].d};
                div_next[k+1][e].r = ge[k][e] ? diff[k][e][CW:0] : trial[k][e][CW:0];
                div_next[k+1][e].w = {div_reg[k][e].w[QW-2:0], ge[k][e]};
                div_next[k+1][e].d = div_reg[k][e].d;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        side_reg[0] <= side0_next;
        div_reg[0]  <= div_next[0];
        for (int k = 0; k < QW; k++)
        begin
            side_reg[k+1] <= side_reg[k];
            div_reg[k+1]  <= div_next[k+1];
        end
    end

    // Stage 3: hit points and range checks against the segment and the edge.
    st3_t                 s3_next, s3_reg;
    logic signed [VW-1:0] qv [NE];
    logic signed [VW-1:0] coord [NE];
    logic signed [VW-1:0] base [NE];

    always_comb
    begin
        s3_next.sx = side_reg[QW].sx;
        s3_next.sy = side_reg[QW].sy;
        for (int e = 0; e < NE; e++)
        begin
            qv[e]    = signed'(VW'(div_reg[QW][e].w));
            base[e]  = (e < 2) ? side_reg[QW].sx : side_reg[QW].sy;
            coord[e] = side_reg[QW].neg[e] ? (base[e] - qv[e]) : (base[e] + qv[e]);
        end
        // Top and bottom edges; a point segment lying on the edge keeps its start x.
        for (int e = 0; e < 2; e++)
        begin
            if (side_reg[QW].dy0)
            begin
                coord[e] = side_reg[QW].sx;
            end
            s3_next.hx[e]  = coord[e];
            s3_next.hy[e]  = (e == 0) ? ty : by;
            s3_next.hit[e] = side_reg[QW].ewin[e]
                          && (!side_reg[QW].dy0 || side_reg[QW].dx0)
                          && seb_pkg::in_range(coord[e], side_reg[QW].sx, side_reg[QW].ex)
                          && seb_pkg::in_range(coord[e], lx, rx);
        end
        for (int e = 2; e < NE; e++)
        begin
            s3_next.hx[e]  = (e == 2) ? lx : rx;
            s3_next.hy[e]  = coord[e];
            s3_next.hit[e] = side_reg[QW].ewin[e]
                          && !side_reg[QW].dx0
                          && seb_pkg::in_range(coord[e], side_reg[QW].sy, side_reg[QW].ey)
                          && seb_pkg::in_range(coord[e], ty, by);
        end
    end

    // Stage 4: offsets from the start point and coincidence of hit points.
    st4_t                 s4_next, s4_reg;
    logic signed [VW-1:0] offx [NE];
    logic signed [VW-1:0] offy [NE];
    logic [VW-1:0]        offx_m [NE];
    logic [VW-1:0]        offy_m [NE];

    always_comb
    begin
        s4_next.hit = s3_reg.hit;
        s4_next.hx  = s3_reg.hx;
        s4_next.hy  = s3_reg.hy;
        for (int e = 0; e < NE; e++)
        begin
            offx[e]   = signed'(s3_reg.hx[e]) - s3_reg.sx;
            offy[e]   = signed'(s3_reg.hy[e]) - s3_reg.sy;
            offx_m[e] = seb_pkg::mag(offx[e]);
            offy_m[e] = seb_pkg::mag(offy[e]);
            s4_next.ax[e] = offx_m[e][CW-1:0];
            s4_next.ay[e] = offy_m[e][CW-1:0];
            for (int j = 0; j < NE; j++)
            begin
                s4_next.eq[e][j] = (s3_reg.hx[e] == s3_reg.hx[j])
                                && (s3_reg.hy[e] == s3_reg.hy[j]);
            end
        end
    end

    // Stage 5: squared distances.
    st5_t          s5_next, s5_reg;
    logic [2*CW-1:0] sqx [NE];
    logic [2*CW-1:0] sqy [NE];

    always_comb
    begin
        s5_next.hit = s4_reg.hit;
        s5_next.hx  = s4_reg.hx;
        s5_next.hy  = s4_reg.hy;
        s5_next.eq  = s4_reg.eq;
        for (int e = 0; e < NE; e++)
        begin
            sqx[e] = (2*CW)'(s4_reg.ax[e]) * (2*CW)'(s4_reg.ax[e]);
            sqy[e] = (2*CW)'(s4_reg.ay[e]) * (2*CW)'(s4_reg.ay[e]);
            s5_next.dsq[e] = SW'(sqx[e]) + SW'(sqy[e]);
        end
    end

    // Stage 6: nearest of each pair; ties go to the earlier edge.
    st6_t s6_next, s6_reg;
    logic take_lo [2];

    always_comb
    begin
        s6_next.hit = s5_reg.hit;
        s6_next.hx  = s5_reg.hx;
        s6_next.hy  = s5_reg.hy;
        s6_next.eq  = s5_reg.eq;
        for (int p = 0; p < 2; p++)
        begin
            take_lo[p] = s5_reg.hit[2*p]
                      && (!s5_reg.hit[2*p+1] || (s5_reg.dsq[2*p] <= s5_reg.dsq[2*p+1]));
            s6_next.pidx[p] = take_lo[p] ? 2'(2*p) : 2'(2*p+1);
            s6_next.pd[p]   = take_lo[p] ? s5_reg.dsq[2*p] : s5_reg.dsq[2*p+1];
            s6_next.phit[p] = s5_reg.hit[2*p] | s5_reg.hit[2*p+1];
        end
    end

    // Output stage: final pick, and the kind merged from all edges hit at that point.
    seb_pkg::hit_res_t res_next, res_reg;
    logic              take01;
    logic [1:0]        best;
    logic              any_hit;
    logic              on_h;
    logic              on_v;

    always_comb
    begin
        take01  = s6_reg.phit[0] && (!s6_reg.phit[1] || (s6_reg.pd[0] <= s6_reg.pd[1]));
        best    = take01 ? s6_reg.pidx[0] : s6_reg.pidx[1];
        any_hit = s6_reg.phit[0] | s6_reg.phit[1];
        on_h    = (s6_reg.hit[0] && s6_reg.eq[0][best])
               || (s6_reg.hit[1] && s6_reg.eq[1][best]);
        on_v    = (s6_reg.hit[2] && s6_reg.eq[2][best])
               || (s6_reg.hit[3] && s6_reg.eq[3][best]);
        if (any_hit)
        begin
            res_next.hit_kind = (on_h ? seb_pkg::KIND_EDGE_H : seb_pkg::KIND_NONE)
                              | (on_v ? seb_pkg::KIND_EDGE_V : seb_pkg::KIND_NONE);
            res_next.hit_x    = signed'(s6_reg.hx[best][CW-1:0]);
            res_next.hit_y    = signed'(s6_reg.hy[best][CW-1:0]);
        end
        else
        begin
            res_next.hit_kind = seb_pkg::KIND_NONE;
            res_next.hit_x    = '0;
            res_next.hit_y    = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg  <= s3_next;
        s4_reg  <= s4_next;
        s5_reg  <= s5_next;
        s6_reg  <= s6_next;
        res_reg <= res_next;
    end

    // Valid bits travel alongside the data.
    logic v3_reg, v4_reg, v5_reg, v6_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            vd_reg   <= '0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            vd_reg   <= {vd_reg[QW-1:0], v1_reg};
            v3_reg   <= vd_reg[QW];
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the segment versus box edge intersection block.
`timescale 1ns / 100ps

module testbench;

    localparam int CW      = seb_pkg::CW;
    localparam int NE      = seb_pkg::NE;
    localparam int LATENCY = CW + 7;

    typedef struct {
        bit                        is_cfg;
        bit                        drain;
        logic [seb_pkg::CFG_IW-1:0] idx;
        logic [CW-1:0]             data;
        seb_pkg::seg_req_t         seg;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    seb_pkg::seg_req_t req = '0;
    logic done;
    seb_pkg::hit_res_t res;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [seb_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    pending_t pending_q[$];
    seb_pkg::hit_res_t hit_expect_q[$];
    int mismatch_count = 0;
    bit stimulus_done = 1'b0;

    // Box held by the predictor, mirrored from the accepted writes.
    longint box_cx = 0, box_cy = 0, box_w = 0, box_h = 0;

    segment_box_edge_intersection u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint sx_coord(logic [CW-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic bit between(longint v, longint a, longint b);
        longint lo;
        longint hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return v >= lo && v <= hi;
    endfunction

    // base + num*scale/den with truncation toward zero.
    function automatic longint interp(longint base, longint num, longint scale, longint den);
        longint unsigned q;
        bit neg;
        q = ((num < 0 ? -num : num) * (scale < 0 ? -scale : scale)) /
            (den < 0 ? -den : den);
        neg = ((num < 0) != (scale < 0)) != (den < 0);
        return neg ? base - longint'(q) : base + longint'(q);
    endfunction

    function automatic seb_pkg::hit_res_t predict_hit(seb_pkg::seg_req_t s);
        longint sx, sy, ex, ey, dx, dy, lx, rx, ty, by, hx, hy, t;
        longint px[4], py[4];
        logic [1:0] kind[4];
        logic [1:0] side;
        int n, j, best;
        bit hit;
        logic [127:0] bd, cd;
        seb_pkg::hit_res_t r;
        sx = sx_coord(s.seg_start_x);
        sy = sx_coord(s.seg_start_y);
        ex = sx_coord(s.seg_end_x);
        ey = sx_coord(s.seg_end_y);
        dx = ex - sx;
        dy = ey - sy;
        lx = box_cx - (box_w >> 1);
        rx = box_cx + (box_w >> 1);
        ty = box_cy - (box_h >> 1);
        by = box_cy + (box_h >> 1);
        n = 0;
        for (int e = 0; e < NE; e++) begin
            hit = 1'b0;
            if (e < 2) begin
                t = (e == 0) ? ty : by;
                if (between(t, sy, ey) && !(dy == 0 && dx != 0)) begin
                    hx = (dy == 0) ? sx : interp(sx, t - sy, dx, dy);
                    hy = t;
                    hit = between(hx, sx, ex) && between(hx, lx, rx);
                end
            end else begin
                t = (e == 2) ? lx : rx;
                if (dx != 0 && between(t, sx, ex)) begin
                    hx = t;
                    hy = interp(sy, t - sx, dy, dx);
                    hit = between(hy, sy, ey) && between(hy, ty, by);
                end
            end
            if (hit) begin
                side = (e < 2) ? seb_pkg::KIND_EDGE_H : seb_pkg::KIND_EDGE_V;
                for (j = 0; j < n; j++)
                    if (px[j] == hx && py[j] == hy)
                        break;
                if (j == n) begin
                    px[n] = hx;
                    py[n] = hy;
                    kind[n] = side;
                    n++;
                end else if (kind[j] != side) begin
                    kind[j] = seb_pkg::KIND_CORNER;
                end
            end
        end
        r = '0;
        if (n == 0)
            return r;
        best = 0;
        bd = (px[0] - sx) * (px[0] - sx) + (py[0] - sy) * (py[0] - sy);
        for (j = 1; j < n; j++) begin
            cd = (px[j] - sx) * (px[j] - sx) + (py[j] - sy) * (py[j] - sy);
            if (cd < bd) begin
                bd = cd;
                best = j;
            end
        end
        r.hit_kind = kind[best];
        r.hit_x = px[best][CW-1:0];
        r.hit_y = py[best][CW-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_box(longint cx, longint cy, longint w, longint h);
        pending_t p;
        p = '{default: '0};
        p.drain = 1'b1;
        pending_q = {pending_q, p};
        p.drain = 1'b0;
        p.is_cfg = 1'b1;
        p.idx = seb_pkg::CFG_CENTER_X; p.data = cx[CW-1:0]; pending_q = {pending_q, p};
        p.idx = seb_pkg::CFG_CENTER_Y; p.data = cy[CW-1:0]; pending_q = {pending_q, p};
        p.idx = seb_pkg::CFG_WIDTH;    p.data = w[CW-1:0];  pending_q = {pending_q, p};
        p.idx = seb_pkg::CFG_HEIGHT;   p.data = h[CW-1:0];  pending_q = {pending_q, p};
    endtask

    task automatic queue_seg(longint a, longint b, longint c, longint d);
        pending_t p;
        p = '{default: '0};
        p.seg.seg_start_x = a[CW-1:0];
        p.seg.seg_start_y = b[CW-1:0];
        p.seg.seg_end_x = c[CW-1:0];
        p.seg.seg_end_y = d[CW-1:0];
        pending_q = {pending_q, p};
    endtask

    function automatic longint near_coord(longint base, longint spread);
        return base + longint'($urandom_range(0, 32'(2 * spread))) - spread;
    endfunction

    task automatic queue_random_phase(int count, longint cx, longint cy, longint w, longint h);
        int mode;
        longint a, b, c, d;
        queue_box(cx, cy, w, h);
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                a = $signed($urandom); b = $signed($urandom);
                c = $signed($urandom); d = $signed($urandom);
            end else if (mode == 2) begin
                // Axis-aligned or point segments.
                a = near_coord(cx, w);
                b = near_coord(cy, h);
                c = ($urandom_range(0, 1)) ? a : near_coord(cx, w);
                d = (c != a) ? b : (($urandom_range(0, 1)) ? b : near_coord(cy, h));
            end else begin
                // Segments around the box so that edges are crossed.
                a = near_coord(cx, w + 16);
                b = near_coord(cy, h + 16);
                c = near_coord(cx, w + 16);
                d = near_coord(cy, h + 16);
                if (mode == 3) begin
                    a = cx + (w >> 1) * ($urandom_range(0, 1) ? 1 : -1);
                    b = cy + (h >> 1) * ($urandom_range(0, 1) ? 1 : -1);
                end
            end
            queue_seg(a, b, c, d);
        end
    endtask

    initial begin
        longint mx, mn;
        mx = (1 <<< (CW - 1)) - 1;
        mn = -(1 <<< (CW - 1));
        // Zero-size box at the origin: every edge coincides.
        queue_seg(-10, -10, 10, 10);
        queue_seg(0, 0, 0, 0);
        queue_seg(5, 5, 5, 5);
        queue_box(100, -200, 400, 300);
        queue_seg(-400, -200, 600, -200);
        queue_seg(-500, -500, 700, 500);
        queue_seg(100, -600, 100, 400);
        queue_seg(-300, -350, -100, -350);
        queue_seg(-100, -350, -100, -350);
        queue_seg(-100, 0, -100, 0);
        queue_seg(-200, -450, 0, -250);
        queue_seg(300, 0, 400, 200);
        queue_seg(mn, mn, mx, mx);
        queue_seg(mx, mn, mn, mx);
        queue_seg(0, 0, 0, 0);
        queue_box(mx, mn, mx, mx);
        queue_seg(mn, mn, mx, mx);
        queue_seg(mx, mx, mn, mn);
        queue_seg(0, mn, mx, 0);
        queue_seg(mx, 0, mx, mn);
        queue_box(mn, mx, 0, mx);
        queue_seg(mn, mn, mn, mx);
        queue_seg(mx, mx, mn, mn);
        queue_box(0, 0, 1, 1);
        queue_seg(-3, -3, 3, 3);
        queue_seg(-1, 0, 1, 0);
        for (int ph = 0; ph < 6; ph++) begin
            longint cx, cy, w, h;
            cx = (ph == 5) ? $signed($urandom) : $signed($urandom_range(0, 40000)) - 20000;
            cy = (ph == 5) ? $signed($urandom) : $signed($urandom_range(0, 40000)) - 20000;
            w = (ph == 0) ? 0 : (ph == 5) ? $urandom_range(0, 32'h7fffff) : $urandom_range(0, 8000);
            h = (ph == 4) ? 3 : (ph == 5) ? $urandom_range(0, 32'h7fffff) : $urandom_range(0, 8000);
            cx = sx_coord(cx[CW-1:0]);
            cy = sx_coord(cy[CW-1:0]);
            queue_random_phase(245, cx, cy, w, h);
        end
        stimulus_done = 1'b1;
    end

    int gap_left = 0;
    int settle_left = 0;

    // Sampled handshake state from the last rising edge.
    logic start_taken = 1'b0;
    logic cfg_taken = 1'b0;
    always @(posedge clk) begin
        start_taken <= start && !busy && rst_n;
        cfg_taken <= cfg_valid && cfg_ready && rst_n;
        if (rst_n && start && !busy)
            hit_expect_q = {hit_expect_q, predict_hit(req)};
        if (rst_n && cfg_valid && cfg_ready) begin
            case (cfg_index)
                seb_pkg::CFG_CENTER_X: box_cx <= sx_coord(cfg_data);
                seb_pkg::CFG_CENTER_Y: box_cy <= sx_coord(cfg_data);
                seb_pkg::CFG_WIDTH:    box_w <= cfg_data[CW-2:0];
                seb_pkg::CFG_HEIGHT:   box_h <= cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    // Driver: one entry per accepted handshake, updates on the falling edge.
    always @(negedge clk) begin
        logic want_start;
        logic want_cfg;
        want_start = start && !start_taken;
        want_cfg = cfg_valid && !cfg_taken;
        if (rst_n && !want_start && !want_cfg) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_q.size() > 0) begin
                if (pending_q[0].drain || pending_q[0].is_cfg) begin
                    // Box writes wait until every request in flight has come out.
                    if (hit_expect_q.size() != 0) begin
                        settle_left <= LATENCY + 4;
                    end else if (settle_left > 0) begin
                        settle_left <= settle_left - 1;
                    end else if (pending_q[0].drain) begin
                        void'(pending_q.pop_front());
                    end else begin
                        cfg_index <= pending_q[0].idx;
                        cfg_data <= pending_q[0].data;
                        void'(pending_q.pop_front());
                        want_cfg = 1'b1;
                    end
                end else begin
                    req <= pending_q[0].seg;
                    void'(pending_q.pop_front());
                    want_start = 1'b1;
                    case ($urandom_range(0, 19))
                        0:       gap_left <= $urandom_range(20, 60);
                        1, 2, 3: gap_left <= $urandom_range(1, 3);
                        default: gap_left <= 0;
                    endcase
                end
            end
        end
        start <= want_start;
        cfg_valid <= want_cfg;
    end

    // Monitor.
    always @(posedge clk) begin
        seb_pkg::hit_res_t want;
        if (rst_n && done) begin
            if (hit_expect_q.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = hit_expect_q.pop_front();
                if (res.hit_kind != want.hit_kind)
                    report_mismatch($sformatf("hit_kind got %0d expected %0d",
                                              res.hit_kind, want.hit_kind));
                if (res.hit_x != want.hit_x)
                    report_mismatch($sformatf("hit_x got %0h expected %0h",
                                              res.hit_x, want.hit_x));
                if (res.hit_y != want.hit_y)
                    report_mismatch($sformatf("hit_y got %0h expected %0h",
                                              res.hit_y, want.hit_y));
            end
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (stimulus_done && pending_q.size() == 0 && !start);
        wait (hit_expect_q.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatch_count == 0 && hit_expect_q.size() == 0)
            $display("PASS segment_box_edge_intersection");
        else
            $display("FAIL segment_box_edge_intersection");
        $finish;
    end

    initial begin
        #10000000;
        $display("FAIL segment_box_edge_intersection");
        $finish;
    end
endmodule

[filelist.f]
design/seb_pkg.sv
design/segment_box_edge_intersection.sv
sim/testbench.sv
